// File: rtl/config_text_tokenizer_assert.svh
// Assertion macros for the configuration text tokenizer.
// Used by the top level; the macros expect clk and rst_n in scope.
`ifndef CONFIG_TEXT_TOKENIZER_ASSERT_SVH
`define CONFIG_TEXT_TOKENIZER_ASSERT_SVH
`ifndef SYNTHESIS
`define CTT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tokenizer assertion failed");
`define CTT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tokenizer assertion failed");
`else
`define CTT_ASSERT_NOW(lbl, ante, cons)
`define CTT_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// File: rtl/ctt_pkg.sv
// Types, codes and per-pass lexer function of the configuration text tokenizer.
// Used by ctt_step and config_text_tokenizer.
package ctt_pkg;

  localparam int STRING_LIMIT = 1024;
  localparam int IDENT_LIMIT  = 512;
  localparam int NEST_LIMIT   = 16;
  localparam int MAX_RES      = 4;
  localparam int FIFO_DEPTH   = 8;

  localparam logic [3:0] K_END    = 4'd0;
  localparam logic [3:0] K_INT    = 4'd1;
  localparam logic [3:0] K_STREND = 4'd2;
  localparam logic [3:0] K_IDEND  = 4'd3;
  localparam logic [3:0] K_TRUE   = 4'd4;
  localparam logic [3:0] K_FALSE  = 4'd5;
  localparam logic [3:0] K_PUNCT  = 4'd6;
  localparam logic [3:0] K_TEXT   = 4'd7;
  localparam logic [3:0] K_ERROR  = 4'd8;

  localparam logic [1:0] KW_NONE  = 2'd0;
  localparam logic [1:0] KW_TRUE  = 2'd1;
  localparam logic [1:0] KW_FALSE = 2'd2;

  localparam logic [4:0] NO_HEX  = 5'd16;
  localparam logic [8:0] ESC_HEX = 9'd256;

  typedef enum logic [4:0] {
    M_IDLE, M_SLASH, M_BLOCK, M_BSTAR, M_BSLASH, M_LINE, M_ZERO, M_MINUS,
    M_DEC, M_HEX, M_IDENT, M_CFIRST, M_CCLOSE, M_CSKIP, M_CESC, M_CX1,
    M_CX2, M_STR, M_SGAP, M_SSKIP, M_SESC, M_SX1, M_SX2
  } mode_t;

  typedef struct packed {
    mode_t        mode;
    logic [63:0]  acc;
    logic         neg;
    logic [4:0]   depth;
    logic [10:0]  tlen;
    logic [23:0]  line;
    logic [3:0]   esc;
    logic [1:0]   kw;
  } lex_state_t;

  localparam lex_state_t LEX_RESET = '{mode: M_IDLE, acc: 64'd0, neg: 1'b0,
                                       depth: 5'd0, tlen: 11'd0, line: 24'd1,
                                       esc: 4'd0, kw: KW_NONE};

  typedef struct packed {
    logic [3:0]  kind;
    logic [63:0] val;
    logic [7:0]  tbyte;
  } emit_t;

  typedef struct packed {
    logic [3:0]  kind;
    logic [63:0] val;
    logic [7:0]  tbyte;
    logic [23:0] line;
    logic        last;
  } res_t;

  typedef struct packed {
    lex_state_t  st;
    logic        again;
    logic [1:0]  n;
    emit_t       e0;
    emit_t       e1;
  } pass_t;

  function automatic logic is_space(logic [7:0] c);
    return c == 8'h09 || c == 8'h0B || c == 8'h0C || c == 8'h0D ||
           c == 8'h20 || c == 8'h7F;
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_letter(logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || c == "_";
  endfunction

  function automatic logic [7:0] to_lower(logic [7:0] c);
    return (c >= "A" && c <= "Z") ? c + 8'h20 : c;
  endfunction

  function automatic logic [4:0] hex_val(logic [7:0] c);
    logic [4:0] v;
    if (is_digit(c)) v = 5'(c - "0");
    else if (c >= "a" && c <= "f") v = 5'(c - "a" + 8'd10);
    else if (c >= "A" && c <= "F") v = 5'(c - "A" + 8'd10);
    else v = NO_HEX;
    return v;
  endfunction

  function automatic logic [8:0] esc_decode(logic [7:0] c);
    logic [8:0] v;
    case (c)
      "0":     v = 9'd0;
      "a":     v = 9'd7;
      "b":     v = 9'd8;
      "t":     v = 9'd9;
      "n":     v = 9'd10;
      "v":     v = 9'd11;
      "f":     v = 9'd12;
      "r":     v = 9'd13;
      "\\":    v = 9'h5C;
      "'":     v = 9'h27;
      "\"":    v = 9'h22;
      "x":     v = ESC_HEX;
      "X":     v = ESC_HEX;
      default: v = 9'h20;
    endcase
    return v;
  endfunction

  function automatic logic [7:0] true_char(logic [1:0] i);
    logic [7:0] ch;
    case (i)
      2'd0:    ch = "t";
      2'd1:    ch = "r";
      2'd2:    ch = "u";
      default: ch = "e";
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] false_char(logic [2:0] i);
    logic [7:0] ch;
    case (i)
      3'd0:    ch = "f";
      3'd1:    ch = "a";
      3'd2:    ch = "l";
      3'd3:    ch = "s";
      default: ch = "e";
    endcase
    return ch;
  endfunction

  function automatic emit_t mk_emit(logic [3:0] kind, logic [63:0] val, logic [7:0] b);
    emit_t e;
    e.kind  = kind;
    e.val   = val;
    e.tbyte = b;
    return e;
  endfunction

  function automatic logic [23:0] line_inc(logic [23:0] l);
    return (l == 24'hFFFFFF) ? l : l + 24'd1;
  endfunction

  // One pass of the lexer state machine: new state, up to two tokens, and
  // whether the same byte must be examined again in the new mode.
  function automatic pass_t lex_pass(lex_state_t s, logic [7:0] c, logic eof);
    pass_t      p;
    logic [4:0] hv;
    logic [4:0] hv2;
    logic [8:0] ev;
    logic [7:0] lc;
    logic [7:0] sv;
    logic       st_txt;
    p       = '0;
    p.st    = s;
    hv      = hex_val(c);
    hv2     = eof ? NO_HEX : hv;
    ev      = esc_decode(c);
    lc      = to_lower(c);
    sv      = c;
    st_txt  = 1'b0;
    case (s.mode)
      M_IDLE: begin
        if (eof) begin
          p.e0 = mk_emit(K_END, 64'd0, 8'd0); p.n = 2'd1;
        end else if (is_space(c)) begin
          p.st.mode = M_IDLE;
        end else if (c == 8'h0A) begin
          p.st.line = line_inc(s.line);
        end else if (c == "/") begin
          p.st.mode = M_SLASH;
        end else if (c == "#") begin
          p.st.mode = M_LINE;
        end else if (c == "0") begin
          p.st.mode = M_ZERO;
        end else if (is_digit(c)) begin
          p.st.acc = 64'(c - "0"); p.st.neg = 1'b0; p.st.mode = M_DEC;
        end else if (c == "-") begin
          p.st.mode = M_MINUS;
        end else if (is_letter(c)) begin
          p.st.tlen = 11'd1;
          p.st.kw   = (lc == "t") ? KW_TRUE : (lc == "f") ? KW_FALSE : KW_NONE;
          p.e0 = mk_emit(K_TEXT, 64'd0, c); p.n = 2'd1;
          p.st.mode = M_IDENT;
        end else if (c == "$") begin
          p.st.acc = 64'd0; p.st.mode = M_HEX;
        end else if (c == "'") begin
          p.st.acc = 64'd0; p.st.mode = M_CFIRST;
        end else if (c == "\"") begin
          p.st.tlen = 11'd0; p.st.mode = M_STR;
        end else if (c == "(" || c == "[" || c == "{" || c == "}" || c == "]" ||
                     c == ")" || c == ";" || c == "=" || c == "," || c == "@") begin
          p.e0 = mk_emit(K_PUNCT, 64'd0, c); p.n = 2'd1;
        end else begin
          p.e0 = mk_emit(K_ERROR, 64'd0, 8'd0); p.n = 2'd1;
        end
      end
      M_SLASH: begin
        if (!eof && c == "*") begin
          p.st.depth = 5'd1; p.st.mode = M_BLOCK;
        end else if (!eof && c == "/") begin
          p.st.mode = M_LINE;
        end else begin
          p.e0 = mk_emit(K_ERROR, 64'd0, 8'd0); p.n = 2'd1;
          p.st.mode = M_IDLE; p.again = 1'b1;
        end
      end
      M_BLOCK: begin
        if (eof) begin
          p.e0 = mk_emit(K_ERROR, 64'd0, 8'd0); p.n = 2'd1;
          p.st.mode = M_IDLE; p.again = 1'b1;
        end else if (c == 8'h0A) begin
          p.st.line = line_inc(s.line);
        end else if (c == "*") begin
          p.st.mode = M_BSTAR;
        end else if (c == "/") begin
          p.st.mode = M_BSLASH;
        end
      end
      M_BSTAR: begin
        if (!eof && c == "/") begin
          p.st.depth = (s.depth != 5'd0) ? s.depth - 5'd1 : s.depth;
          p.st.mode  = (p.st.depth != 5'd0) ? M_BLOCK : M_IDLE;
        end else begin
          p.st.mode = M_BLOCK; p.again = 1'b1;
        end
      end
      M_BSLASH: begin
        if (!eof && c == "*") begin
          if (s.depth < 5'(NEST_LIMIT)) p.st.depth = s.depth + 5'd1;
          else begin
            p.e0 = mk_emit(K_ERROR, 64'd0, 8'd0); p.n = 2'd1;
          end
          p.st.mode = M_BLOCK;
        end else begin
          p.st.mode = M_BLOCK; p.again = 1'b1;
        end
      end
      M_LINE: begin
        if (eof || c == 8'h0A) begin
          p.st.mode = M_IDLE; p.again = 1'b1;
        end
      end
      M_ZERO: begin
        p.st.acc = 64'd0;
        if (!eof && (c == "x" || c == "X")) begin
          p.st.mode = M_HEX;
        end else begin
          p.st.neg = 1'b0; p.st.mode = M_DEC; p.again = 1'b1;
        end
      end
      M_MINUS: begin
        if (!eof && is_digit(c)) begin
          p.st.acc = 64'(c - "0"); p.st.neg = 1'b1; p.st.mode = M_DEC;
        end else begin
          p.e0 = mk_emit(K_ERROR, 64'd0, 8'd0); p.n = 2'd1;
          p.st.mode = M_IDLE; p.again = 1'b1;
        end
      end
      M_DEC: begin
        if (eof) begin
          p.e0 = mk_emit(K_ERROR, 64'd0, 8'd0);
          p.e1 = mk_emit(K_INT, 64'd0, 8'd0); p.n = 2'd2;
          p.st.mode = M_IDLE; p.again = 1'b1;
        end else if (is_digit(c)) begin
          p.st.acc = {s.acc[60:0], 3'b000} + {s.acc[62:0], 1'b0} + 64'(c - "0");
        end else begin
          p.e0 = mk_emit(K_INT, s.neg ? 64'd0 - s.acc : s.acc, 8'd0); p.n = 2'd1;
          p.st.mode = M_IDLE; p.again = 1'b1;
        end
      end
      M_HEX: begin
        if (eof) begin
          p.e0 = mk_emit(K_ERROR, 64'd0, 8'd0);
          p.e1 = mk_emit(K_INT, s.acc, 8'd0); p.n = 2'd2;
          p.st.mode = M_IDLE; p.again = 1'b1;
        end else if (hv != NO_HEX) begin
          p.st.acc = {s.acc[59:0], hv[3:0]};
        end else begin
          p.e0 = mk_emit(K_INT, s.acc, 8'd0); p.n = 2'd1;
          p.st.mode = M_IDLE; p.again = 1'b1;
        end
      end
      M_IDENT: begin
        if (eof) begin
          p.e0 = mk_emit(K_ERROR, 64'd0, 8'd0); p.n = 2'd1;
          p.st.mode = M_IDLE; p.again = 1'b1;
        end else if (is_letter(c) || is_digit(c) || c == "@") begin
          if (s.tlen < 11'(IDENT_LIMIT)) begin
            if (s.kw == KW_TRUE && !(s.tlen < 11'd4 && lc == true_char(s.tlen[1:0])))
              p.st.kw = KW_NONE;
            if (s.kw == KW_FALSE && !(s.tlen < 11'd5 && lc == false_char(s.tlen[2:0])))
              p.st.kw = KW_NONE;
            p.st.tlen = s.tlen + 11'd1;
            p.e0 = mk_emit(K_TEXT, 64'd0, c); p.n = 2'd1;
          end else if (s.tlen == 11'(IDENT_LIMIT)) begin
            p.e0 = mk_emit(K_ERROR, 64'd0, 8'd0); p.n = 2'd1;
            p.st.tlen = 11'(IDENT_LIMIT + 1);
            p.st.kw   = KW_NONE;
          end
        end else begin
          if (s.kw == KW_TRUE && s.tlen == 11'd4)
            p.e0 = mk_emit(K_TRUE, 64'd0, 8'd0);
          else if (s.kw == KW_FALSE && s.tlen == 11'd5)
            p.e0 = mk_emit(K_FALSE, 64'd0, 8'd0);
          else
            p.e0 = mk_emit(K_IDEND, 64'd0, 8'd0);
          p.n = 2'd1;
          p.st.mode = M_IDLE; p.again = 1'b1;
        end
      end
      M_CFIRST: begin
        if (eof) begin
          p.st.acc = 64'd0; p.st.mode = M_CCLOSE; p.again = 1'b1;
        end else if (c == "\\") begin
          p.st.mode = M_CESC;
        end else begin
          p.st.acc = 64'(c); p.st.mode = M_CCLOSE;
        end
      end
      M_CCLOSE: begin
        if (eof) begin
          p.e0 = mk_emit(K_ERROR, 64'd0, 8'd0);
          p.e1 = mk_emit(K_INT, s.acc, 8'd0); p.n = 2'd2;
          p.st.mode = M_IDLE; p.again = 1'b1;
        end else if (c == "'") begin
          p.e0 = mk_emit(K_INT, s.acc, 8'd0); p.n = 2'd1;
          p.st.mode = M_IDLE;
        end else begin
          p.e0 = mk_emit(K_ERROR, 64'd0, 8'd0); p.n = 2'd1;
          if (c == 8'h0A) begin
            p.e1 = mk_emit(K_INT, s.acc, 8'd0); p.n = 2'd2;
            p.st.mode = M_IDLE; p.again = 1'b1;
          end else begin
            p.st.mode = M_CSKIP;
          end
        end
      end
      M_CSKIP: begin
        if (eof || c == 8'h0A) begin
          p.e0 = mk_emit(K_INT, s.acc, 8'd0); p.n = 2'd1;
          p.st.mode = M_IDLE; p.again = 1'b1;
        end else if (c == "'") begin
          p.e0 = mk_emit(K_INT, s.acc, 8'd0); p.n = 2'd1;
          p.st.mode = M_IDLE;
        end
      end
      M_CESC: begin
        if (eof) begin
          p.st.acc = 64'd0; p.st.mode = M_CCLOSE; p.again = 1'b1;
        end else if (ev == ESC_HEX) begin
          p.st.mode = M_CX1;
        end else begin
          p.st.acc = 64'(ev[7:0]); p.st.mode = M_CCLOSE;
        end
      end
      M_CX1: begin
        if (eof) begin
          p.st.acc = 64'd0; p.st.mode = M_CCLOSE; p.again = 1'b1;
        end else if (hv != NO_HEX) begin
          p.st.esc = hv[3:0]; p.st.mode = M_CX2;
        end else begin
          p.st.acc = 64'h20; p.st.mode = M_CCLOSE;
        end
      end
      M_CX2: begin
        p.st.mode = M_CCLOSE;
        if (hv2 != NO_HEX) begin
          p.st.acc = 64'({s.esc, hv2[3:0]});
        end else begin
          p.st.acc = 64'(s.esc); p.again = 1'b1;
        end
      end
      M_STR: begin
        if (eof) begin
          p.e0 = mk_emit(K_ERROR, 64'd0, 8'd0);
          p.e1 = mk_emit(K_STREND, 64'd0, 8'd0); p.n = 2'd2;
          p.st.mode = M_IDLE; p.again = 1'b1;
        end else if (s.tlen >= 11'(STRING_LIMIT)) begin
          p.e0 = mk_emit(K_ERROR, 64'd0, 8'd0); p.n = 2'd1;
          p.st.mode = M_SSKIP; p.again = 1'b1;
        end else if (c == "\"") begin
          p.st.mode = M_SGAP;
        end else if (c == "\\") begin
          p.st.mode = M_SESC;
        end else begin
          st_txt = 1'b1; sv = c;
        end
      end
      M_SSKIP: begin
        if (eof) begin
          p.e0 = mk_emit(K_STREND, 64'd0, 8'd0); p.n = 2'd1;
          p.st.mode = M_IDLE; p.again = 1'b1;
        end else if (c == "\"") begin
          p.e0 = mk_emit(K_STREND, 64'd0, 8'd0); p.n = 2'd1;
          p.st.mode = M_IDLE;
        end
      end
      M_SGAP: begin
        if (eof) begin
          p.e0 = mk_emit(K_STREND, 64'd0, 8'd0); p.n = 2'd1;
          p.st.mode = M_IDLE; p.again = 1'b1;
        end else if (is_space(c)) begin
          p.st.mode = M_SGAP;
        end else if (c == 8'h0A) begin
          p.st.line = line_inc(s.line);
        end else if (c == "\"") begin
          p.st.mode = M_STR;
        end else begin
          p.e0 = mk_emit(K_STREND, 64'd0, 8'd0); p.n = 2'd1;
          p.st.mode = M_IDLE; p.again = 1'b1;
        end
      end
      M_SESC: begin
        if (eof) begin
          p.st.mode = M_STR; p.again = 1'b1;
        end else if (ev == ESC_HEX) begin
          p.st.mode = M_SX1;
        end else begin
          st_txt = 1'b1; sv = ev[7:0];
        end
      end
      M_SX1: begin
        if (eof) begin
          p.st.mode = M_STR; p.again = 1'b1;
        end else if (hv != NO_HEX) begin
          p.st.esc = hv[3:0]; p.st.mode = M_SX2;
        end else begin
          st_txt = 1'b1; sv = 8'h20;
        end
      end
      M_SX2: begin
        st_txt = 1'b1;
        if (hv2 != NO_HEX) begin
          sv = {s.esc, hv2[3:0]};
        end else begin
          sv = {4'd0, s.esc}; p.again = 1'b1;
        end
      end
      default: begin
        p.st.mode = M_IDLE; p.again = 1'b1;
      end
    endcase
    if (st_txt) begin
      p.e0 = mk_emit(K_TEXT, 64'd0, sv); p.n = 2'd1;
      if (s.tlen < 11'(STRING_LIMIT)) p.st.tlen = s.tlen + 11'd1;
      p.st.mode = M_STR;
    end
    return p;
  endfunction

endpackage

// File: rtl/ctt_step.sv
// Combinational lexer step: runs the state machine passes for one byte and
// gathers up to four result words. Depends on ctt_pkg.
module ctt_step (
  input  ctt_pkg::lex_state_t          cur,
  input  logic [7:0]                   c,
  input  logic                         eof,
  output ctt_pkg::lex_state_t          nxt,
  output logic [2:0]                   res_n,
  output ctt_pkg::res_t [3:0]          res
);

  ctt_pkg::pass_t      pv;
  ctt_pkg::lex_state_t st;
  logic                act;
  logic [2:0]          cnt;

  always_comb begin
    st  = cur;
    act = 1'b1;
    cnt = 3'd0;
    pv  = '0;
    res = '0;
    for (int k = 0; k < ctt_pkg::MAX_RES; k++) begin
      if (act) begin
        pv = ctt_pkg::lex_pass(st, c, eof);
        st = pv.st;
        if (pv.n != 2'd0 && cnt < 3'd4) begin
          res[cnt[1:0]] = '{kind: pv.e0.kind, val: pv.e0.val, tbyte: pv.e0.tbyte,
                            line: cur.line, last: 1'b0};
          cnt = cnt + 3'd1;
        end
        if (pv.n == 2'd2 && cnt < 3'd4) begin
          res[cnt[1:0]] = '{kind: pv.e1.kind, val: pv.e1.val, tbyte: pv.e1.tbyte,
                            line: cur.line, last: 1'b0};
          cnt = cnt + 3'd1;
        end
        act = pv.again;
      end
    end
    if (cnt != 3'd0) res[2'(cnt - 3'd1)].last = 1'b1;
    res_n = cnt;
    nxt   = eof ? ctt_pkg::LEX_RESET : st;
  end

endmodule

// File: rtl/config_text_tokenizer.sv
// Configuration text tokenizer: one byte per word in, token words out.
// Each accepted byte is registered, then its result words are written to the queue that drives the output.
// Throughput: one input word per cycle while each byte gives at most one token
// and the output is not stalled; tokens pass through an 8-entry queue, and input stalls while it holds over four.
// Synchronous active-low reset returns the lexer to idle at line one and
// empties the queue.
module config_text_tokenizer (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_source_byte,
  input  logic               in_end_of_input,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [3:0]         out_token_kind,
  output logic signed [63:0] out_int_value,
  output logic [7:0]         out_text_byte,
  output logic [23:0]        out_line_number,
  output logic               out_last_in_run
);

`include "config_text_tokenizer_assert.svh"

  logic                in_vld_r, in_vld_nxt;
  logic [7:0]          in_byte_r;
  logic                in_eof_r;
  ctt_pkg::lex_state_t state_r, state_nxt;
  ctt_pkg::res_t [3:0] res;
  logic [2:0]          res_n;
  ctt_pkg::res_t       fifo_r [ctt_pkg::FIFO_DEPTH];
  logic [2:0]          wr_ptr_r, wr_ptr_nxt;
  logic [2:0]          rd_ptr_r, rd_ptr_nxt;
  logic [3:0]          cnt_r, cnt_nxt;
  logic                process, accept, pop;
  ctt_pkg::res_t       head;

  ctt_step u_step (
    .cur   (state_r),
    .c     (in_byte_r),
    .eof   (in_eof_r),
    .nxt   (state_nxt),
    .res_n (res_n),
    .res   (res)
  );

  assign process   = in_vld_r && (cnt_r <= 4'd4);
  assign in_stall  = in_vld_r && !process;
  assign accept    = in_valid && !in_stall;
  assign pop       = out_valid && !out_stall;
  assign head      = fifo_r[rd_ptr_r];

  assign out_valid       = cnt_r != 4'd0;
  assign out_token_kind  = head.kind;
  assign out_int_value   = head.val;
  assign out_text_byte   = head.tbyte;
  assign out_line_number = head.line;
  assign out_last_in_run = head.last;

  always_comb begin
    in_vld_nxt = accept ? 1'b1 : (process ? 1'b0 : in_vld_r);
    wr_ptr_nxt = process ? wr_ptr_r + res_n : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 3'd1 : rd_ptr_r;
    cnt_nxt    = cnt_r + (process ? {1'b0, res_n} : 4'd0) - {3'd0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
      state_r  <= ctt_pkg::LEX_RESET;
      wr_ptr_r <= 3'd0;
      rd_ptr_r <= 3'd0;
      cnt_r    <= 4'd0;
    end else begin
      in_vld_r <= in_vld_nxt;
      if (process) state_r <= state_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_byte_r <= in_source_byte;
      in_eof_r  <= in_end_of_input;
    end
    if (process) begin
      for (int j = 0; j < ctt_pkg::MAX_RES; j++) begin
        if (3'(j) < res_n) fifo_r[wr_ptr_r + 3'(j)] <= res[j];
      end
    end
  end

  `CTT_ASSERT_NOW(a_queue_bound, 1'b1, cnt_r <= 4'(ctt_pkg::FIFO_DEPTH))
  `CTT_ASSERT_NEXT(a_eof_resets, process && in_eof_r, state_r == ctt_pkg::LEX_RESET)
  `CTT_ASSERT_NOW(a_line_nonzero, 1'b1, state_r.line != 24'd0)
  `CTT_ASSERT_NEXT(a_stall_holds, in_stall, in_vld_r)

endmodule
